// File: src/fff_pkg.sv
// Shared types, constants and helper functions for the framebuffer flood-fill block.
package fff_pkg;

  // Store and stack geometry.
  localparam int MAX_WIDTH   = 128;
  localparam int MAX_HEIGHT  = 128;
  localparam int STACK_DEPTH = 4096;
  localparam int STORE_WORDS = MAX_WIDTH * MAX_HEIGHT;

  localparam int X_W     = $clog2(MAX_WIDTH);
  localparam int Y_W     = $clog2(MAX_HEIGHT);
  localparam int POS_W   = X_W + Y_W;
  localparam int ADDR_W  = $clog2(STORE_WORDS);
  localparam int SP_W    = $clog2(STACK_DEPTH);
  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int DIM_W   = 8;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  // Reset values of the frame size registers.
  localparam logic [DIM_W-1:0] RESET_WIDTH  = 8'd128;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 8'd128;

  // Byte-swap masks.
  localparam logic [31:0] MASK_LO16 = 32'h0000FFFF;
  localparam logic [31:0] MASK_HI16 = 32'hFFFF0000;
  localparam logic [31:0] MASK_LO8  = 32'h00FF00FF;
  localparam logic [31:0] MASK_HI8  = 32'hFF00FF00;

  // Request codes.
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_SET  = 2'd1;
  localparam logic [1:0] REQ_FILL = 2'd2;
  localparam logic [1:0] REQ_READ = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_OOF  = 2'd1;
  localparam logic [1:0] ST_SAME = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  // Neighbor order for pushes.
  localparam logic [1:0] NB_RIGHT = 2'd0;
  localparam logic [1:0] NB_LEFT  = 2'd1;
  localparam logic [1:0] NB_UP    = 2'd2;
  localparam logic [1:0] NB_DOWN  = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [31:0]        color;
  } req_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  status;
  } res_item_t;

  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } dims_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADDR,
    S_EXEC,
    S_RD_WAIT,
    S_TGT,
    S_POP,
    S_POP_WAIT,
    S_PIX_RD,
    S_PIX_CMP,
    S_PUSH,
    S_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       latch_req;
    logic       calc_req_addr;
    logic       calc_pop_addr;
    logic       store_wr;
    logic       store_rd;
    logic       latch_data;
    logic       push_seed;
    logic       pop;
    logic       push;
    logic       clear_count;
    logic [1:0] nb_sel;
    logic       res_load;
    logic [1:0] res_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] req_type;
    logic       oof;
    logic       same_color;
    logic       pix_match;
    logic       stack_empty;
    logic       stack_full;
    logic       nb_ok;
  } stat_t;

  // Reverse the byte order of a 32-bit word.
  function automatic logic [31:0] swap_bytes(input logic [31:0] c);
    logic [31:0] t;
    t = ((c & MASK_LO16) << 16) | ((c & MASK_HI16) >> 16);
    return ((t & MASK_LO8) << 8) | ((t & MASK_HI8) >> 8);
  endfunction

  // Clamp a size register into the range 1..max.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage

// File: src/framebuffer_flood_fill_unit.sv
// Top level of the framebuffer flood-fill block: size registers, result register and wiring.
//
// Usage: requests enter on in_item with in_valid/in_stall; each request gives exactly one
// result on out_item with out_valid/out_stall. An item moves at a clock edge where valid is
// high and stall is low. The frame size is written through cfg_we/cfg_index/cfg_wdata;
// the user must write it only while the block is idle, which the block does not enforce;
// a zero size acts as one and values above 128 act as 128. A fill walks the stack: each
// entry goes through a stack pop, an address calculation, a registered store read and a
// compare; a repainted pixel then takes a push step for each of its four neighbors on the
// single stack write port, and an entry whose pixel no longer matches is dropped.
// One request is in flight at a time; in_stall is low only while the controller is idle.
// A finished result sits in the output register while the next request is accepted; when
// the receiver stalls and that register is still full, the controller waits before
// delivering the next result.
// Reset (rst_n low, synchronous) sets the size registers to 128 by 128, empties the stack
// and drops out_valid. The pixel store is not cleared and must be written before it is read.
module framebuffer_flood_fill_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  fff_pkg::req_item_t                    in_item,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output fff_pkg::res_item_t                    out_item,
  input  logic                                  cfg_we,
  input  logic [fff_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [fff_pkg::DIM_W-1:0]             cfg_wdata
);
  import fff_pkg::*;

  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  res_item_t        out_item_r;
  dims_t            dims;
  cmd_t             cmd;
  stat_t            stat;
  logic             in_ready;
  logic             out_free;
  logic [31:0]      res_data;

  // Frame size registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RESET_WIDTH;
      height_r <= RESET_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  width_r  <= cfg_wdata;
        CFG_FRAME_HEIGHT: height_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Active frame size.
  assign dims.w = clamp_dim(width_r, DIM_W'(MAX_WIDTH));
  assign dims.h = clamp_dim(height_r, DIM_W'(MAX_HEIGHT));

  // Output register: free when empty or being taken this cycle.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_item_r.read_data <= res_data;
      out_item_r.status    <= cmd.res_status;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign in_stall  = !in_ready;

  fff_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  fff_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .dims     (dims),
    .cmd      (cmd),
    .stat     (stat),
    .res_data (res_data)
  );

endmodule

// File: src/fff_datapath.sv
// Datapath of the flood-fill block: request registers, pixel store, fill stack and address logic.
module fff_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  fff_pkg::req_item_t in_item,
  input  fff_pkg::dims_t     dims,
  input  fff_pkg::cmd_t      cmd,
  output fff_pkg::stat_t     stat,
  output logic [31:0]        res_data
);
  import fff_pkg::*;

  // Request registers.
  logic [1:0]         req_type_r;
  logic signed [15:0] pos_x_r;
  logic signed [15:0] pos_y_r;
  logic [31:0]        wcolor_r;
  logic [31:0]        res_data_r;
  logic [31:0]        target_r;
  logic [POS_W-1:0]   pos_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;

  // Memories and their registered read data.
  logic [31:0]       store_mem [STORE_WORDS];
  logic [POS_W-1:0]  stack_mem [STACK_DEPTH];
  logic [31:0]       rd_data_r;
  logic [POS_W-1:0]  stk_pos_r;

  logic [X_W-1:0]      ax;
  logic [Y_W-1:0]      ay;
  logic [DIM_W-1:0]    row;
  logic [2*DIM_W-1:0]  prod;
  logic [ADDR_W-1:0]   addr_nxt;
  logic [POS_W-1:0]    calc_pos;
  logic [X_W-1:0]      px;
  logic [Y_W-1:0]      py;
  logic                nb_ok;
  logic [POS_W-1:0]    nb_pos;
  logic                stk_we;
  logic [SP_W-1:0]     stk_wa;
  logic [POS_W-1:0]    stk_wd;
  logic [SP_W-1:0]     stk_ra;
  logic                x_in;
  logic                y_in;

  // Latch the accepted request; the stored color is pre-swapped except for raw loads.
  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_type_r <= in_item.req_type;
      pos_x_r    <= in_item.pos_x;
      pos_y_r    <= in_item.pos_y;
      wcolor_r   <= (in_item.req_type == REQ_LOAD) ? in_item.color
                                                   : swap_bytes(in_item.color);
    end
  end

  // Read result data is zero unless a read completes.
  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      res_data_r <= '0;
    end else if (cmd.latch_data) begin
      res_data_r <= rd_data_r;
    end
  end

  // The target color is the seed's stored word.
  always_ff @(posedge clk) begin
    if (cmd.push_seed) begin
      target_r <= rd_data_r;
    end
  end

  // Frame bounds of the request position.
  assign x_in = !pos_x_r[15] && (pos_x_r[14:0] < 15'(dims.w));
  assign y_in = !pos_y_r[15] && (pos_y_r[14:0] < 15'(dims.h));

  // Store address: x + w * (h - 1 - y), from the request or a popped entry.
  always_comb begin
    if (cmd.calc_pop_addr) begin
      calc_pos = stk_pos_r;
    end else begin
      calc_pos = {pos_y_r[Y_W-1:0], pos_x_r[X_W-1:0]};
    end
    ax       = calc_pos[X_W-1:0];
    ay       = calc_pos[POS_W-1:X_W];
    row      = dims.h - DIM_W'(1) - DIM_W'(ay);
    prod     = dims.w * row;
    addr_nxt = ADDR_W'(prod) + ADDR_W'(ax);
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_req_addr || cmd.calc_pop_addr) begin
      addr_r <= addr_nxt;
      pos_r  <= calc_pos;
    end
  end

  // Pixel store: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.store_wr) begin
      store_mem[addr_r] <= wcolor_r;
    end
    if (cmd.store_rd) begin
      rd_data_r <= store_mem[addr_r];
    end
  end

  // Neighbor of the current pixel and whether it lies in the frame.
  assign px = pos_r[X_W-1:0];
  assign py = pos_r[POS_W-1:X_W];

  always_comb begin
    case (cmd.nb_sel)
      NB_RIGHT: begin
        nb_ok  = (DIM_W'(px) + DIM_W'(1)) < dims.w;
        nb_pos = {py, X_W'(px + 1'b1)};
      end
      NB_LEFT: begin
        nb_ok  = (px != '0);
        nb_pos = {py, X_W'(px - 1'b1)};
      end
      NB_UP: begin
        nb_ok  = (DIM_W'(py) + DIM_W'(1)) < dims.h;
        nb_pos = {Y_W'(py + 1'b1), px};
      end
      NB_DOWN: begin
        nb_ok  = (py != '0);
        nb_pos = {Y_W'(py - 1'b1), px};
      end
      default: begin
        nb_ok  = 1'b0;
        nb_pos = pos_r;
      end
    endcase
  end

  // Fill stack: pushes write at the count, pops read below it.
  assign stk_we = cmd.push_seed || cmd.push;
  assign stk_wa = cmd.push_seed ? '0 : count_r[SP_W-1:0];
  assign stk_wd = cmd.push_seed ? pos_r : nb_pos;
  assign stk_ra = SP_W'(count_r - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_wa] <= stk_wd;
    end
    if (cmd.pop) begin
      stk_pos_r <= stack_mem[stk_ra];
    end
  end

  // Stack fill count.
  always_comb begin
    count_nxt = count_r;
    if (cmd.clear_count) begin
      count_nxt = '0;
    end else if (cmd.push_seed) begin
      count_nxt = CNT_W'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end else if (cmd.push) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Status toward the controller.
  assign stat.req_type    = req_type_r;
  assign stat.oof         = !(x_in && y_in);
  assign stat.same_color  = (rd_data_r == wcolor_r);
  assign stat.pix_match   = (rd_data_r == target_r);
  assign stat.stack_empty = (count_r == '0);
  assign stat.stack_full  = (count_r == CNT_W'(STACK_DEPTH));
  assign stat.nb_ok       = nb_ok;

  assign res_data = res_data_r;

endmodule

// File: src/fff_ctrl.sv
// Controller state machine that sequences requests and the stack walk of a fill.
module fff_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           out_free,
  input  fff_pkg::stat_t stat,
  output logic           in_ready,
  output fff_pkg::cmd_t  cmd
);
  import fff_pkg::*;

  state_t     state_r;
  state_t     state_nxt;
  logic [1:0] k_r;
  logic [1:0] k_nxt;
  logic [1:0] status_r;
  logic [1:0] status_nxt;

  // State, neighbor counter and pending status.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      k_r      <= '0;
      status_r <= ST_DONE;
    end else begin
      state_r  <= state_nxt;
      k_r      <= k_nxt;
      status_r <= status_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    status_nxt     = status_r;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.nb_sel     = k_r;
    cmd.res_status = status_r;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_req = 1'b1;
          state_nxt     = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd.calc_req_addr = 1'b1;
        state_nxt         = S_EXEC;
      end
      S_EXEC: begin
        if (stat.oof) begin
          status_nxt = ST_OOF;
          state_nxt  = S_FINISH;
        end else begin
          case (stat.req_type)
            REQ_LOAD, REQ_SET: begin
              cmd.store_wr = 1'b1;
              status_nxt   = ST_DONE;
              state_nxt    = S_FINISH;
            end
            REQ_FILL: begin
              cmd.store_rd = 1'b1;
              state_nxt    = S_TGT;
            end
            default: begin
              cmd.store_rd = 1'b1;
              state_nxt    = S_RD_WAIT;
            end
          endcase
        end
      end
      S_RD_WAIT: begin
        cmd.latch_data = 1'b1;
        status_nxt     = ST_DONE;
        state_nxt      = S_FINISH;
      end
      S_TGT: begin
        if (stat.same_color) begin
          status_nxt = ST_SAME;
          state_nxt  = S_FINISH;
        end else begin
          cmd.push_seed = 1'b1;
          state_nxt     = S_POP;
        end
      end
      S_POP: begin
        if (stat.stack_empty) begin
          status_nxt = ST_DONE;
          state_nxt  = S_FINISH;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        cmd.calc_pop_addr = 1'b1;
        state_nxt         = S_PIX_RD;
      end
      S_PIX_RD: begin
        cmd.store_rd = 1'b1;
        state_nxt    = S_PIX_CMP;
      end
      S_PIX_CMP: begin
        if (stat.pix_match) begin
          cmd.store_wr = 1'b1;
          k_nxt        = NB_RIGHT;
          state_nxt    = S_PUSH;
        end else begin
          state_nxt = S_POP;
        end
      end
      S_PUSH: begin
        if (stat.nb_ok && stat.stack_full) begin
          // Overflow ends the fill and empties the stack.
          cmd.clear_count = 1'b1;
          status_nxt      = ST_OVF;
          state_nxt       = S_FINISH;
        end else begin
          cmd.push = stat.nb_ok;
          if (k_r == NB_DOWN) begin
            state_nxt = S_POP;
          end else begin
            k_nxt = k_r + 2'd1;
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
